@@ src/jcs_pkg.sv @@
// Package for the JSONC comment stripper: character codes, scan mode codes,
// the byte-order mark table and the result bundle shared by the scan logic and the top level.
// No dependencies.
package jcs_pkg;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_QUOTE = 8'h22;

	localparam logic [2:0] MODE_TEXT       = 3'd0;
	localparam logic [2:0] MODE_STR        = 3'd1;
	localparam logic [2:0] MODE_STR_ESC    = 3'd2;
	localparam logic [2:0] MODE_SLASH      = 3'd3;
	localparam logic [2:0] MODE_LINE       = 3'd4;
	localparam logic [2:0] MODE_BLOCK      = 3'd5;
	localparam logic [2:0] MODE_BLOCK_STAR = 3'd6;

	localparam logic [1:0] PHASE_START = 2'd0;
	localparam logic [1:0] PHASE_DONE  = 2'd3;

	localparam int MAX_RESULTS = 3;

	typedef logic [2:0] mode_t;
	typedef logic [1:0] phase_t;

	typedef struct packed {
		logic [MAX_RESULTS-1:0][7:0] bytes;
		logic [1:0]                  num;
		logic                        bare;
		logic                        doc_end;
		mode_t                       mode_next;
		phase_t                      phase_next;
	} jcs_result_t;

	function automatic logic [7:0] mark_byte(input phase_t idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = 8'hEF;
			2'd1: b = 8'hBB;
			2'd2: b = 8'hBF;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

@@ src/jcs_scan.sv @@
// Combinational scan step of the JSONC comment stripper: one input byte, the current
// scan mode and mark phase in, up to three result bytes and the next state out.
// Depends on jcs_pkg.
module jcs_scan import jcs_pkg::*; (
	input  mode_t       mode,
	input  phase_t      phase,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output jcs_result_t res
);

	logic [MAX_RESULTS-1:0][7:0] ob;
	logic [1:0]                  cnt;
	mode_t                       mode_n;
	phase_t                      phase_n;
	logic                        do_scan;
	logic                        do_text;

	always_comb begin
		ob = '0;
		cnt = 2'd0;
		mode_n = mode;
		phase_n = phase;
		do_scan = 1'b0;
		do_text = 1'b0;

		if (phase != PHASE_DONE) begin
			if (in_byte == mark_byte(phase)) begin
				phase_n = phase + 2'd1;
				if (in_last && phase_n != PHASE_DONE) begin
					ob[cnt] = mark_byte(2'd0);
					cnt = cnt + 2'd1;
					if (phase_n == 2'd2) begin
						ob[cnt] = mark_byte(2'd1);
						cnt = cnt + 2'd1;
					end
				end
			end else begin
				if (phase != PHASE_START) begin
					ob[cnt] = mark_byte(2'd0);
					cnt = cnt + 2'd1;
				end
				if (phase == 2'd2) begin
					ob[cnt] = mark_byte(2'd1);
					cnt = cnt + 2'd1;
				end
				phase_n = PHASE_DONE;
				do_scan = 1'b1;
			end
		end else begin
			do_scan = 1'b1;
		end

		if (do_scan) begin
			case (mode)
				MODE_STR: begin
					ob[cnt] = in_byte;
					cnt = cnt + 2'd1;
					if (in_byte == CH_BSL) begin
						mode_n = MODE_STR_ESC;
					end else if (in_byte == CH_QUOTE) begin
						mode_n = MODE_TEXT;
					end
				end
				MODE_STR_ESC: begin
					ob[cnt] = in_byte;
					cnt = cnt + 2'd1;
					mode_n = MODE_STR;
				end
				MODE_SLASH: begin
					if (in_byte == CH_SLASH) begin
						mode_n = MODE_LINE;
					end else if (in_byte == CH_STAR) begin
						mode_n = MODE_BLOCK;
					end else begin
						ob[cnt] = CH_SLASH;
						cnt = cnt + 2'd1;
						do_text = 1'b1;
					end
				end
				MODE_LINE: begin
					if (in_byte == CH_NL) begin
						ob[cnt] = in_byte;
						cnt = cnt + 2'd1;
						mode_n = MODE_TEXT;
					end
				end
				MODE_BLOCK, MODE_BLOCK_STAR: begin
					if (!in_last) begin
						if (mode == MODE_BLOCK_STAR && in_byte == CH_SLASH) begin
							mode_n = MODE_TEXT;
						end else if (in_byte == CH_STAR) begin
							mode_n = MODE_BLOCK_STAR;
						end else begin
							if (in_byte == CH_NL) begin
								ob[cnt] = in_byte;
								cnt = cnt + 2'd1;
							end
							mode_n = MODE_BLOCK;
						end
					end
				end
				default: begin
					do_text = 1'b1;
				end
			endcase
		end

		if (do_text) begin
			if (in_byte == CH_QUOTE) begin
				ob[cnt] = in_byte;
				cnt = cnt + 2'd1;
				mode_n = MODE_STR;
			end else if (in_byte == CH_SLASH) begin
				mode_n = MODE_SLASH;
			end else begin
				ob[cnt] = in_byte;
				cnt = cnt + 2'd1;
				mode_n = MODE_TEXT;
			end
		end

		res.bare = 1'b0;
		if (in_last) begin
			if (mode_n == MODE_SLASH) begin
				ob[cnt] = CH_SLASH;
				cnt = cnt + 2'd1;
			end
			if (cnt == 2'd0) begin
				res.bare = 1'b1;
				cnt = 2'd1;
			end
			mode_n = MODE_TEXT;
			phase_n = PHASE_START;
		end

		res.bytes = ob;
		res.num = cnt;
		res.doc_end = in_last;
		res.mode_next = mode_n;
		res.phase_next = phase_n;
	end

endmodule

@@ src/jsonc_comment_stripper_unit.sv @@
// Emits the stripped stream via an input register, a combinational scan step and a result
// register drained one result a cycle while m_tready is high. A byte with two or three
// results stalls the input until its last result is taken; other bytes are taken one per
// cycle unless the output stalls. Depends on jcs_pkg and jcs_scan. A document end always
// yields at least one result, flagged with tlast.
module jsonc_comment_stripper_unit import jcs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,   // in_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [1:0] m_tuser,   // [0] has_byte, [1] run_last
	output logic       m_tlast    // doc_end
);

	logic                        valid_s1;
	logic [7:0]                  byte_s1;
	logic                        last_s1;
	mode_t                       mode_q;
	phase_t                      phase_q;
	jcs_result_t                 res;
	logic                        res_valid_q;
	logic [MAX_RESULTS-1:0][7:0] res_bytes_q;
	logic [1:0]                  res_num_q;
	logic                        res_bare_q;
	logic                        res_end_q;
	logic [1:0]                  ptr_q;
	logic                        take;
	logic                        item_last;
	logic                        advance;

	jcs_scan u_scan (
		.mode    (mode_q),
		.phase   (phase_q),
		.in_byte (byte_s1),
		.in_last (last_s1),
		.res     (res)
	);

	assign take      = m_tvalid && m_tready;
	assign item_last = (ptr_q == res_num_q - 2'd1);
	assign advance   = valid_s1 && (!res_valid_q || (take && item_last));
	assign s_tready  = !valid_s1 || advance;

	assign m_tvalid = res_valid_q;
	assign m_tdata  = res_bytes_q[ptr_q];
	assign m_tuser  = {item_last, !res_bare_q};
	assign m_tlast  = res_end_q && item_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_TEXT;
			phase_q <= PHASE_START;
			res_valid_q <= 1'b0;
			ptr_q <= 2'd0;
		end else begin
			if (advance && res.num != 2'd0) begin
				res_valid_q <= 1'b1;
				ptr_q <= 2'd0;
			end else if (take) begin
				if (item_last) begin
					res_valid_q <= 1'b0;
				end else begin
					ptr_q <= ptr_q + 2'd1;
				end
			end
			if (advance) begin
				mode_q <= res.mode_next;
				phase_q <= res.phase_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.num != 2'd0) begin
			res_bytes_q <= res.bytes;
			res_num_q <= res.num;
			res_bare_q <= res.bare;
			res_end_q <= res.doc_end;
		end
	end

	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (ptr_q < res_num_q))
		else $error("Result pointer runs past the stored result count.");

	a_bare_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_bare_q) |-> (res_num_q == 2'd1 && res_end_q))
		else $error("A bare result must be a single end marker.");

	a_end_resets_state: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (mode_q == MODE_TEXT && phase_q == PHASE_START))
		else $error("Scan state not returned to start after document end.");

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (res_valid_q && res_end_q))
		else $error("Document end produced no result.");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for jsonc_comment_stripper_unit: it drives JSONC documents as byte
// streams and checks the stripped output against a predictor kept in a scoreboard class.
// Depends on jcs_pkg and the unit under test.
module tb import jcs_pkg::*; ();

	localparam int RANDOM_ITEMS = 240;
	localparam int STALL_LIMIT  = 2000;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       run_last;
		logic       doc_end;
	} strip_out_t;

	class strip_scoreboard;
		localparam logic [2:0][7:0] BOM_SEQ = {8'hBF, 8'hBB, 8'hEF};

		mode_t      mode;
		phase_t     phase;
		strip_out_t due_out[$];
		strip_out_t step_out[$];
		int         n_req;
		int         n_res;
		int         n_docs;
		int         n_bad;

		function new();
			mode = MODE_TEXT;
			phase = PHASE_START;
			n_req = 0;
			n_res = 0;
			n_docs = 0;
			n_bad = 0;
		endfunction

		function void put(logic [7:0] b);
			strip_out_t r;
			if (step_out.size() < MAX_RESULTS) begin
				r.out_byte = b;
				r.has_byte = 1'b1;
				r.run_last = 1'b0;
				r.doc_end = 1'b0;
				step_out.insert(step_out.size(), r);
			end
		endfunction

		function void text_byte(logic [7:0] b);
			if (b == CH_QUOTE) begin
				put(b);
				mode = MODE_STR;
			end else if (b == CH_SLASH) begin
				mode = MODE_SLASH;
			end else begin
				put(b);
				mode = MODE_TEXT;
			end
		endfunction

		function void scan_byte(logic [7:0] b, logic last);
			case (mode)
				MODE_STR: begin
					put(b);
					if (b == CH_BSL)
						mode = MODE_STR_ESC;
					else if (b == CH_QUOTE)
						mode = MODE_TEXT;
				end
				MODE_STR_ESC: begin
					put(b);
					mode = MODE_STR;
				end
				MODE_SLASH: begin
					if (b == CH_SLASH) begin
						mode = MODE_LINE;
					end else if (b == CH_STAR) begin
						mode = MODE_BLOCK;
					end else begin
						put(CH_SLASH);
						text_byte(b);
					end
				end
				MODE_LINE: begin
					if (b == CH_NL) begin
						put(b);
						mode = MODE_TEXT;
					end
				end
				MODE_BLOCK, MODE_BLOCK_STAR: begin
					// The final byte of an unterminated block comment is dropped.
					if (!last) begin
						if (mode == MODE_BLOCK_STAR && b == CH_SLASH) begin
							mode = MODE_TEXT;
						end else if (b == CH_STAR) begin
							mode = MODE_BLOCK_STAR;
						end else begin
							if (b == CH_NL)
								put(b);
							mode = MODE_BLOCK;
						end
					end
				end
				default: text_byte(b);
			endcase
		endfunction

		function void note_request(logic [7:0] b, logic last);
			int i;
			strip_out_t r;
			step_out.delete();
			n_req++;
			if (phase < PHASE_DONE) begin
				if (b == BOM_SEQ[phase]) begin
					phase = phase + 2'd1;
				end else begin
					for (i = 0; i < phase && i < 2; i++)
						put(BOM_SEQ[i]);
					phase = PHASE_DONE;
					scan_byte(b, last);
				end
				if (last && phase < PHASE_DONE) begin
					for (i = 0; i < phase && i < 2; i++)
						put(BOM_SEQ[i]);
				end
			end else begin
				scan_byte(b, last);
			end
			if (last) begin
				if (mode == MODE_SLASH)
					put(CH_SLASH);
				if (step_out.size() == 0) begin
					r = '0;
					step_out.insert(step_out.size(), r);
				end
				r = step_out.pop_back();
				r.doc_end = 1'b1;
				step_out.insert(step_out.size(), r);
				mode = MODE_TEXT;
				phase = PHASE_START;
				n_docs++;
			end
			if (step_out.size() > 0) begin
				r = step_out.pop_back();
				r.run_last = 1'b1;
				step_out.insert(step_out.size(), r);
			end
			foreach (step_out[k])
				due_out.insert(due_out.size(), step_out[k]);
		endfunction

		function void check_result(logic [7:0] data, logic [1:0] user, logic last);
			strip_out_t got;
			strip_out_t want;
			got.out_byte = data;
			got.has_byte = user[0];
			got.run_last = user[1];
			got.doc_end = last;
			n_res++;
			if (due_out.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("%0t: unexpected result byte=%h has=%b run_last=%b doc_end=%b",
						$time, got.out_byte, got.has_byte, got.run_last, got.doc_end);
			end else begin
				want = due_out.pop_front();
				if (got !== want) begin
					n_bad++;
					if (n_bad <= 10) begin
						$display("%0t: result %0d mismatch: expected byte=%h has=%b run_last=%b doc_end=%b",
							$time, n_res, want.out_byte, want.has_byte, want.run_last,
							want.doc_end);
						$display("    got byte=%h has=%b run_last=%b doc_end=%b",
							got.out_byte, got.has_byte, got.run_last, got.doc_end);
					end
				end
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b1;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;
	logic       m_tlast;

	strip_scoreboard chk = new();
	logic [7:0]      doc_bytes[$];
	logic            idle_on = 1'b0;
	int              idle_cycles = 0;

	jsonc_comment_stripper_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			chk.check_result(m_tdata, m_tuser, m_tlast);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d cycles without a transfer", idle_cycles);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_item(input logic [7:0] b, input logic last);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		chk.note_request(b, last);
	endtask

	task automatic send_doc();
		for (int i = 0; i < doc_bytes.size(); i++)
			send_item(doc_bytes[i], i == doc_bytes.size() - 1);
		doc_bytes.delete();
	endtask

	function automatic void add_byte(input logic [7:0] b);
		doc_bytes.insert(doc_bytes.size(), b);
	endfunction

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	function automatic logic [7:0] text_char();
		string pool;
		pool = "{}[]:,a1 \t\n";
		return pool[$urandom_range(0, pool.len() - 1)];
	endfunction

	task automatic build_random_doc();
		int n_tok;
		int cut;
		case ($urandom_range(0, 5))
			0: add_text("\xEF\xBB\xBF");
			1: add_byte(8'hEF);
			2: add_text("\xEF\xBB");
			default: ;
		endcase
		n_tok = $urandom_range(1, 5);
		repeat (n_tok) begin
			case ($urandom_range(0, 9))
				0: add_byte(8'($urandom_range(0, 255)));
				3: begin
					add_byte(CH_QUOTE);
					repeat ($urandom_range(0, 3)) begin
						if ($urandom_range(0, 2) == 0) begin
							add_byte(CH_BSL);
							add_byte(8'($urandom_range(0, 255)));
						end else begin
							add_byte(text_char());
						end
					end
					add_byte(CH_QUOTE);
				end
				4: begin
					add_text("//");
					repeat ($urandom_range(0, 3))
						add_byte(8'($urandom_range(0, 255)));
					add_byte(CH_NL);
				end
				5: begin
					add_text("/*");
					repeat ($urandom_range(0, 4)) begin
						case ($urandom_range(0, 3))
							0: add_byte(CH_STAR);
							1: add_byte(CH_NL);
							2: add_byte(CH_SLASH);
							default: add_byte(8'($urandom_range(0, 255)));
						endcase
					end
					add_text("*/");
				end
				6: begin
					add_byte(CH_SLASH);
					case ($urandom_range(0, 2))
						0: add_byte(CH_QUOTE);
						1: add_byte(8'($urandom_range(0, 255)));
						default: add_byte(text_char());
					endcase
				end
				default: add_byte(text_char());
			endcase
		end
		// Some documents are cut short so that they end inside a token.
		if (doc_bytes.size() > 1 && $urandom_range(0, 4) == 0) begin
			cut = $urandom_range(1, doc_bytes.size() - 1);
			repeat (cut)
				void'(doc_bytes.pop_back());
		end
	endtask

	initial begin
		bit drained;
		int start_req;
		drained = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_text("\xEF\xBB\xBF");
		send_doc();
		add_text("\xEF\xBB/");
		send_doc();
		add_text("\xEF\"\\\"");
		send_doc();
		add_text("/*\n*//");
		add_byte(8'h00);
		add_byte(8'hFF);
		send_doc();
		add_text("//");
		add_byte(8'hFF);
		add_text("\n/*\n");
		send_doc();
		add_text("//");
		add_byte(8'h00);
		send_doc();

		start_req = chk.n_req;
		while (chk.n_req - start_req < RANDOM_ITEMS) begin
			idle_on = (chk.n_req - start_req < RANDOM_ITEMS - 50) && ($urandom_range(0, 2) != 0);
			if (!drained && chk.n_req - start_req > RANDOM_ITEMS / 2) begin
				// Hold off new requests until the output side has caught up.
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (chk.due_out.size() != 0)
					@(posedge clk);
				drained = 1'b1;
			end
			build_random_doc();
			send_doc();
		end
		idle_on = 1'b0;
		s_tvalid <= 1'b0;
		while (chk.due_out.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (chk.due_out.size() != 0) begin
			chk.n_bad += chk.due_out.size();
			$display("%0d expected results never arrived", chk.due_out.size());
		end
		$display("ran %0d documents: %0d bytes in, %0d results out, %0d mismatches",
			chk.n_docs, chk.n_req, chk.n_res, chk.n_bad);
		if (chk.n_bad == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
